FILE: rtl/core/pole_pkg.sv
package pole_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int LINK_W  = 7;

  localparam logic [LINK_W-1:0] NIL_LINK = 7'd127;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_FREEHD,
    S_LOCATE,
    S_WALK,
    S_PRED,
    S_INS_WR1,
    S_INS_WR2,
    S_DEL_LNK,
    S_DEL_FREE,
    S_DUMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [LINK_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [LINK_W-1:0] raddr;
  } link_port_t;

  typedef struct packed {
    logic                      we;
    logic [LINK_W-1:0]         waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic                      re;
    logic [LINK_W-1:0]         raddr;
  } data_port_t;

  typedef struct packed {
    data_port_t data;
    link_port_t fwd;
    link_port_t bwd;
  } mem_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    logic [LINK_W-1:0]         fwd;
    logic [LINK_W-1:0]         bwd;
  } mem_rsp_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        entry_count;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      last_of_run;
  } result_t;

endpackage

FILE: rtl/core/pole_if.sv
interface pole_in_if
  import pole_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output operation, output value, output position, input ready);
  modport sink (input valid, input operation, input value, input position, output ready);
endinterface

interface pole_out_if
  import pole_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic [COUNT_W-1:0]        entry_count;
  logic signed [VALUE_W-1:0] entry_value;
  logic                      last_of_run;

  modport source (
    output valid, output status, output entry_count, output entry_value, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input status, input entry_count, input entry_value, input last_of_run,
    output ready
  );
endinterface

FILE: rtl/core/pole_store.sv
module pole_store
  import pole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [VALUE_W-1:0] data_mem_r [CAPACITY];
  logic [LINK_W-1:0]         fwd_mem_r  [CAPACITY];
  logic [LINK_W-1:0]         bwd_mem_r  [CAPACITY];

  logic signed [VALUE_W-1:0] data_rd_r;
  logic [LINK_W-1:0]         fwd_rd_r;
  logic [LINK_W-1:0]         bwd_rd_r;

  always_ff @(posedge clk) begin
    if (req.data.we) begin
      data_mem_r[req.data.waddr[AW-1:0]] <= req.data.wdata;
    end
    if (req.data.re) begin
      data_rd_r <= data_mem_r[req.data.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.fwd.we) begin
      fwd_mem_r[req.fwd.waddr[AW-1:0]] <= req.fwd.wdata;
    end
    if (req.fwd.re) begin
      fwd_rd_r <= fwd_mem_r[req.fwd.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.bwd.we) begin
      bwd_mem_r[req.bwd.waddr[AW-1:0]] <= req.bwd.wdata;
    end
    if (req.bwd.re) begin
      bwd_rd_r <= bwd_mem_r[req.bwd.raddr[AW-1:0]];
    end
  end

  assign rsp.data = data_rd_r;
  assign rsp.fwd  = fwd_rd_r;
  assign rsp.bwd  = bwd_rd_r;

endmodule

FILE: rtl/core/pole_oreg.sv
module pole_oreg
  import pole_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  result_t           load_data,
  output logic              can_load,
  pole_out_if.source        out_chan
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign can_load = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.status      = data_r.status;
  assign out_chan.entry_count = data_r.entry_count;
  assign out_chan.entry_value = data_r.entry_value;
  assign out_chan.last_of_run = data_r.last_of_run;

endmodule

FILE: rtl/core/pole_ctrl.sv
module pole_ctrl
  import pole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pole_in_if.sink    in_chan,
  output mem_req_t   req,
  input  mem_rsp_t   rsp,
  input  logic       can_load,
  output logic       load,
  output result_t    load_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LINK_W-1:0] CAP_LINK = LINK_W'(CAPACITY);
  localparam logic [CW-1:0]     CAP_CNT  = CW'(CAPACITY);

  state_t                    state_r, state_nxt;
  status_t                   status_r, status_nxt;
  logic                      is_ins_r, is_ins_nxt;
  logic                      at_end_r, at_end_nxt;
  logic [AW-1:0]             k_r, k_nxt;
  logic [AW-1:0]             steps_r, steps_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [LINK_W-1:0]         s_r, s_nxt;
  logic [LINK_W-1:0]         succ_r, succ_nxt;
  logic [LINK_W-1:0]         pred_r, pred_nxt;
  logic [LINK_W-1:0]         first_r, first_nxt;
  logic [LINK_W-1:0]         final_r, final_nxt;
  logic [LINK_W-1:0]         free_head_r, free_head_nxt;
  logic [CW-1:0]             fresh_r, fresh_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             dn_r, dn_nxt;

  logic                      found;
  logic [LINK_W-1:0]         tgt;
  logic [POS_W-1:0]          cnt_p;
  logic                      full;
  logic                      dump_last;

  function automatic logic is_slot(input logic [LINK_W-1:0] l);
    return l < CAP_LINK;
  endfunction

  assign in_chan.ready = (state_r == S_IDLE);
  assign cnt_p     = POS_W'(count_r);
  assign full      = (count_r == CAP_CNT);
  assign dump_last = ((dn_r + CW'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    is_ins_nxt    = is_ins_r;
    at_end_nxt    = at_end_r;
    k_nxt         = k_r;
    steps_nxt     = steps_r;
    value_nxt     = value_r;
    s_nxt         = s_r;
    succ_nxt      = succ_r;
    pred_nxt      = pred_r;
    first_nxt     = first_r;
    final_nxt     = final_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    count_nxt     = count_r;
    dn_nxt        = dn_r;
    req           = '0;
    load          = 1'b0;
    load_data     = '0;
    found         = 1'b0;
    tgt           = NIL_LINK;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          value_nxt  = in_chan.value;
          status_nxt = ST_OK;
          k_nxt      = '0;
          at_end_nxt = 1'b0;
          unique case (op_t'(in_chan.operation))
            OP_INS_FIRST: begin
              is_ins_nxt = 1'b1;
              at_end_nxt = (count_r == '0);
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            OP_INS_LAST: begin
              is_ins_nxt = 1'b1;
              at_end_nxt = 1'b1;
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            OP_INS_AT: begin
              is_ins_nxt = 1'b1;
              k_nxt      = AW'(in_chan.position - POS_W'(1));
              at_end_nxt = (in_chan.position == cnt_p + POS_W'(1));
              if (in_chan.position == '0 || in_chan.position > cnt_p + POS_W'(1)) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            OP_DEL_FIRST: begin
              is_ins_nxt = 1'b0;
              at_end_nxt = (count_r == CW'(1));
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_LOCATE;
              end
            end
            OP_DEL_LAST: begin
              is_ins_nxt = 1'b0;
              at_end_nxt = 1'b1;
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_LOCATE;
              end
            end
            OP_DEL_AT: begin
              is_ins_nxt = 1'b0;
              k_nxt      = AW'(in_chan.position - POS_W'(1));
              at_end_nxt = (in_chan.position == cnt_p);
              if (in_chan.position == '0 || in_chan.position > cnt_p) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_LOCATE;
              end
            end
            OP_DUMP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                req.data.re    = 1'b1;
                req.data.raddr = first_r;
                req.fwd.re     = 1'b1;
                req.fwd.raddr  = first_r;
                dn_nxt         = '0;
                state_nxt      = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (is_slot(free_head_r)) begin
          req.fwd.re    = 1'b1;
          req.fwd.raddr = free_head_r;
          s_nxt         = free_head_r;
          state_nxt     = S_FREEHD;
        end else begin
          s_nxt     = LINK_W'(fresh_r);
          fresh_nxt = fresh_r + CW'(1);
          state_nxt = S_LOCATE;
        end
      end

      S_FREEHD: begin
        free_head_nxt = rsp.fwd;
        state_nxt     = S_LOCATE;
      end

      S_LOCATE: begin
        if (at_end_r) begin
          found = 1'b1;
          tgt   = is_ins_r ? NIL_LINK : final_r;
        end else if (k_r == '0) begin
          found = 1'b1;
          tgt   = first_r;
        end else begin
          req.fwd.re    = 1'b1;
          req.fwd.raddr = first_r;
          steps_nxt     = k_r - AW'(1);
          state_nxt     = S_WALK;
        end
      end

      S_WALK: begin
        if (steps_r == '0) begin
          found = 1'b1;
          tgt   = rsp.fwd;
        end else begin
          req.fwd.re    = 1'b1;
          req.fwd.raddr = rsp.fwd;
          steps_nxt     = steps_r - AW'(1);
        end
      end

      S_PRED: begin
        pred_nxt  = rsp.bwd;
        state_nxt = S_INS_WR1;
      end

      S_INS_WR1: begin
        req.data.we    = 1'b1;
        req.data.waddr = s_r;
        req.data.wdata = value_r;
        req.fwd.we     = 1'b1;
        req.fwd.waddr  = s_r;
        req.fwd.wdata  = succ_r;
        req.bwd.we     = 1'b1;
        req.bwd.waddr  = s_r;
        req.bwd.wdata  = pred_r;
        state_nxt      = S_INS_WR2;
      end

      S_INS_WR2: begin
        if (is_slot(pred_r)) begin
          req.fwd.we    = 1'b1;
          req.fwd.waddr = pred_r;
          req.fwd.wdata = s_r;
        end else begin
          first_nxt = s_r;
        end
        if (is_slot(succ_r)) begin
          req.bwd.we    = 1'b1;
          req.bwd.waddr = succ_r;
          req.bwd.wdata = s_r;
        end else begin
          final_nxt = s_r;
        end
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end

      S_DEL_LNK: begin
        if (is_slot(rsp.bwd)) begin
          req.fwd.we    = 1'b1;
          req.fwd.waddr = rsp.bwd;
          req.fwd.wdata = rsp.fwd;
        end else begin
          first_nxt = rsp.fwd;
        end
        if (is_slot(rsp.fwd)) begin
          req.bwd.we    = 1'b1;
          req.bwd.waddr = rsp.fwd;
          req.bwd.wdata = rsp.bwd;
        end else begin
          final_nxt = rsp.bwd;
        end
        state_nxt = S_DEL_FREE;
      end

      S_DEL_FREE: begin
        req.fwd.we    = 1'b1;
        req.fwd.waddr = s_r;
        req.fwd.wdata = free_head_r;
        free_head_nxt = s_r;
        count_nxt     = count_r - CW'(1);
        state_nxt     = S_RESP;
      end

      S_DUMP: begin
        if (can_load) begin
          load                  = 1'b1;
          load_data.status      = ST_OK;
          load_data.entry_count = COUNT_W'(count_r);
          load_data.entry_value = rsp.data;
          load_data.last_of_run = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            req.data.re    = 1'b1;
            req.data.raddr = rsp.fwd;
            req.fwd.re     = 1'b1;
            req.fwd.raddr  = rsp.fwd;
            dn_nxt         = dn_r + CW'(1);
          end
        end
      end

      S_RESP: begin
        if (can_load) begin
          load                  = 1'b1;
          load_data.status      = status_r;
          load_data.entry_count = COUNT_W'(count_r);
          load_data.entry_value = '0;
          load_data.last_of_run = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (found) begin
      if (is_ins_r) begin
        succ_nxt = tgt;
        if (is_slot(tgt)) begin
          req.bwd.re    = 1'b1;
          req.bwd.raddr = tgt;
          state_nxt     = S_PRED;
        end else begin
          pred_nxt  = final_r;
          state_nxt = S_INS_WR1;
        end
      end else begin
        s_nxt         = tgt;
        req.fwd.re    = 1'b1;
        req.fwd.raddr = tgt;
        req.bwd.re    = 1'b1;
        req.bwd.raddr = tgt;
        state_nxt     = S_DEL_LNK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= NIL_LINK;
      final_r     <= NIL_LINK;
      free_head_r <= NIL_LINK;
      fresh_r     <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      final_r     <= final_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    is_ins_r <= is_ins_nxt;
    at_end_r <= at_end_nxt;
    k_r      <= k_nxt;
    steps_r  <= steps_nxt;
    value_r  <= value_nxt;
    s_r      <= s_nxt;
    succ_r   <= succ_nxt;
    pred_r   <= pred_nxt;
    dn_r     <= dn_nxt;
  end

endmodule

FILE: rtl/core/positional_ordered_list_engine.sv
// An insert or a delete at list index k walks the forward link memory, one read per cycle;
// an insert into a freed slot first reads the free-list head, and an append or a delete of
// the last entry needs no walk. A dump, or an item that needs no list change, gives its first
// result from S_DUMP or S_RESP once the output register can take it; a dump then gives one
// entry per cycle while the output does not stall. The next transfer is taken once the last
// result is loaded. Reset empties the list at once; unused slots come from a fill count.
module positional_ordered_list_engine
  import pole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pole_in_if.sink     in_chan,
  pole_out_if.source  out_chan
);

  mem_req_t req;
  mem_rsp_t rsp;
  logic     can_load;
  logic     load;
  result_t  load_data;

  pole_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .req       (req),
    .rsp       (rsp),
    .can_load  (can_load),
    .load      (load),
    .load_data (load_data)
  );

  pole_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  pole_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (load_data),
    .can_load  (can_load),
    .out_chan  (out_chan)
  );

endmodule

FILE: test/positional_ordered_list_engine_test.sv
module positional_ordered_list_engine_test
  import pole_pkg::*;
;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int MAX_POS = LIST_CAP + 1;
  localparam int RANDOM_ITEMS = 360;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
  } list_req_t;

  logic clk;
  logic rst_n;

  pole_in_if  in_chan ();
  pole_out_if out_chan ();

  positional_ordered_list_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  list_req_t                 pending_reqs[$];
  list_req_t                 next_req;
  logic signed [VALUE_W-1:0] list_contents[$];
  result_t                   awaited_results[$];
  int                        est_len;
  int                        queued_total;
  int                        reqs_issued;
  int                        reqs_accepted;
  int                        mismatch_count;
  int                        gap_left;
  int                        stall_left;
  int                        idle_cycles;
  bit                        in_calm;
  bit                        out_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int send_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_cycles();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return OP_DUMP;
    if (r < 6) return OP_UNUSED;
    if ($urandom_range(0, 99) < ins_pct) begin
      case ($urandom_range(0, 2))
        0: return OP_INS_FIRST;
        1: return OP_INS_LAST;
        default: return OP_INS_AT;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return OP_DEL_FIRST;
      1: return OP_DEL_LAST;
      default: return OP_DEL_AT;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(logic [OP_W-1:0] op);
    int hi;
    hi = (op == OP_INS_AT) ? est_len + 1 : est_len;
    if ((op == OP_INS_AT || op == OP_DEL_AT) && hi > 0 && $urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 3))
        0: return POS_W'(1);
        1: return POS_W'(hi);
        default: return POS_W'($urandom_range(1, hi));
      endcase
    end
    return POS_W'($urandom_range(0, MAX_POS));
  endfunction

  // The generator tracks the list length on its own so that positions can be aimed
  // at the valid range long before the item reaches the block.
  task automatic queue_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
                          logic [POS_W-1:0] pos);
    list_req_t req;
    req.op = op;
    req.value = value;
    req.pos = pos;
    pending_reqs.push_back(req);
    queued_total++;
    case (op)
      OP_INS_FIRST, OP_INS_LAST: if (est_len < LIST_CAP) est_len++;
      OP_INS_AT: if (pos >= 1 && pos <= est_len + 1 && est_len < LIST_CAP) est_len++;
      OP_DEL_FIRST, OP_DEL_LAST: if (est_len > 0) est_len--;
      OP_DEL_AT: if (pos >= 1 && pos <= est_len) est_len--;
      default: ;
    endcase
  endtask

  task automatic queue_random(int ins_pct);
    logic [OP_W-1:0] op;
    op = pick_op(ins_pct);
    queue_op(op, rand_value(), pick_pos(op));
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || reqs_accepted != reqs_issued ||
           awaited_results.size() != 0);
  endtask

  task automatic apply_list_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
    int      cnt;
    status_t st;
    result_t res;
    cnt = list_contents.size();
    st = ST_OK;
    res.entry_value = '0;
    res.last_of_run = 1'b1;
    if (op == OP_DUMP) begin
      if (cnt == 0) begin
        res.status = ST_EMPTY;
        res.entry_count = '0;
        awaited_results.push_back(res);
      end else begin
        for (int i = 0; i < cnt; i++) begin
          res.status = ST_OK;
          res.entry_count = COUNT_W'(cnt);
          res.entry_value = list_contents[i];
          res.last_of_run = (i == cnt - 1);
          awaited_results.push_back(res);
        end
      end
    end else begin
      case (op)
        OP_INS_FIRST: begin
          if (cnt >= LIST_CAP) st = ST_FULL;
          else list_contents.push_front(value);
        end
        OP_INS_LAST: begin
          if (cnt >= LIST_CAP) st = ST_FULL;
          else list_contents.push_back(value);
        end
        OP_INS_AT: begin
          if (pos < 1 || pos > cnt + 1) st = ST_BADPOS;
          else if (cnt >= LIST_CAP) st = ST_FULL;
          else list_contents.insert(int'(pos) - 1, value);
        end
        OP_DEL_FIRST: begin
          if (cnt == 0) st = ST_EMPTY;
          else void'(list_contents.pop_front());
        end
        OP_DEL_LAST: begin
          if (cnt == 0) st = ST_EMPTY;
          else void'(list_contents.pop_back());
        end
        OP_DEL_AT: begin
          if (pos < 1 || pos > cnt) st = ST_BADPOS;
          else list_contents.delete(int'(pos) - 1);
        end
        default: ;
      endcase
      res.status = st;
      res.entry_count = COUNT_W'(list_contents.size());
      awaited_results.push_back(res);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: status %0d entry_count %0d entry_value %0d last_of_run %0b",
             out_chan.status, out_chan.entry_count, out_chan.entry_value,
             out_chan.last_of_run);
      mismatch_count++;
    end else begin
      want = awaited_results.pop_front();
      if (out_chan.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_chan.status);
        mismatch_count++;
      end
      if (out_chan.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, out_chan.entry_count);
        mismatch_count++;
      end
      if (out_chan.entry_value !== want.entry_value) begin
        $error("entry_value: expected %0d, got %0d", want.entry_value, out_chan.entry_value);
        mismatch_count++;
      end
      if (out_chan.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_chan.last_of_run);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) reqs_accepted++;
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          in_chan.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          in_chan.operation <= next_req.op;
          in_chan.value <= next_req.value;
          in_chan.position <= next_req.pos;
          in_chan.valid <= 1'b1;
          gap_left <= send_gap(in_calm);
          reqs_issued++;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        apply_list_op(in_chan.operation, in_chan.value, in_chan.position);
      if (out_chan.valid && out_chan.ready) check_result();
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        stall_left <= stall_cycles() - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_len;
    int ins_pct;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.operation = OP_INS_FIRST;
    in_chan.value = '0;
    in_chan.position = '0;
    out_chan.ready = 1'b0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty-list corner cases, extremes of value, every positional edge, the unused code.
    queue_op(OP_DEL_FIRST, '0, '0);
    queue_op(OP_DEL_LAST, '0, '0);
    queue_op(OP_DEL_AT, '0, POS_W'(1));
    queue_op(OP_DUMP, '0, '0);
    queue_op(OP_INS_AT, VAL_MAX, POS_W'(0));
    queue_op(OP_INS_AT, VAL_MAX, POS_W'(2));
    queue_op(OP_INS_AT, VAL_MIN, POS_W'(1));
    queue_op(OP_INS_FIRST, VAL_MAX, '0);
    queue_op(OP_INS_LAST, '1, '0);
    queue_op(OP_INS_AT, '0, POS_W'(4));
    queue_op(OP_INS_AT, 32'sh5a5a_a5a5, POS_W'(2));
    queue_op(OP_UNUSED, '0, '0);
    queue_op(OP_DUMP, '0, '0);
    queue_op(OP_DEL_AT, '0, POS_W'(5));
    queue_op(OP_DEL_AT, '0, POS_W'(1));
    queue_op(OP_DEL_AT, '0, POS_W'(2));
    queue_op(OP_DEL_AT, '0, POS_W'(0));
    queue_op(OP_DEL_AT, '0, POS_W'(MAX_POS));
    queue_op(OP_INS_AT, VAL_MIN, POS_W'(MAX_POS));
    queue_op(OP_DUMP, '0, '0);
    queue_op(OP_DEL_LAST, '0, '0);
    queue_op(OP_DEL_FIRST, '0, '0);
    queue_op(OP_DUMP, '0, '0);
    wait_for_drain();

    while (est_len < LIST_CAP) queue_random(100);
    queue_op(OP_INS_FIRST, rand_value(), pick_pos(OP_INS_FIRST));
    queue_op(OP_INS_LAST, rand_value(), pick_pos(OP_INS_LAST));
    queue_op(OP_INS_AT, rand_value(), POS_W'(MAX_POS));
    queue_op(OP_INS_AT, rand_value(), POS_W'(0));
    queue_op(OP_DUMP, rand_value(), pick_pos(OP_DUMP));
    wait_for_drain();

    while (est_len > 0) queue_random(0);
    queue_op(OP_DEL_FIRST, rand_value(), pick_pos(OP_DEL_FIRST));
    queue_op(OP_DEL_LAST, rand_value(), pick_pos(OP_DEL_LAST));
    queue_op(OP_DEL_AT, rand_value(), pick_pos(OP_DEL_AT));
    queue_op(OP_DUMP, rand_value(), pick_pos(OP_DUMP));

    while (queued_total < RANDOM_ITEMS) begin
      while (pending_reqs.size() > 0) @(negedge clk);
      if ($urandom_range(0, 3) == 0) wait_for_drain();
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: ins_pct = 30;
        1: ins_pct = 50;
        default: ins_pct = 75;
      endcase
      phase_len = $urandom_range(15, 40);
      for (int i = 0; i < phase_len; i++) queue_random(ins_pct);
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pole_pkg.sv
rtl/core/pole_if.sv
rtl/core/pole_store.sv
rtl/core/pole_oreg.sv
rtl/core/pole_ctrl.sv
rtl/core/positional_ordered_list_engine.sv
test/positional_ordered_list_engine_test.sv
